>>> rtl/svpd_pkg.sv
// svpd_pkg: shared types, widths, register codes and sector tables for the
// space vector pwm duty pipeline. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svpd_pkg;

   // field and datapath widths
   localparam int FRAC_BITS_DEF = 15;
   localparam int IN_FRAC       = 15;
   localparam int IN_W          = 24;
   localparam int U_W           = 26;
   localparam int UM_W          = 26;
   localparam int TS_W          = 16;
   localparam int UDC_W         = 8;
   localparam int CMP_W         = 16;
   localparam int SEC_W         = 3;
   localparam int XM_W          = UM_W + TS_W + 1 - IN_FRAC;
   localparam int SUM_W         = XM_W + 1;
   localparam int LANES_XYZ     = 3;
   localparam int LANES_T       = 2;
   localparam int STEP_XYZ      = 4;
   localparam int STEP_T        = 1;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   // sqrt3 held with 21 fraction bits
   localparam logic [21:0] SQRT3_Q21 = 22'd3632374;

   // register reset values
   localparam logic [UDC_W-1:0] UDC_RST    = 8'd24;
   localparam logic [TS_W-1:0]  TS_RST     = 16'd3600;
   localparam logic [TS_W-1:0]  PERIOD_RST = 16'd3600;
   localparam logic [TS_W-1:0]  LIMIT_RST  = 16'd3500;

   typedef enum logic [1:0] {
      REG_UDC    = 2'd0,
      REG_TS     = 2'd1,
      REG_PERIOD = 2'd2,
      REG_LIMIT  = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      PH_A = 2'd0,
      PH_B = 2'd1,
      PH_C = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      LN_X = 2'd0,
      LN_Y = 2'd1,
      LN_Z = 2'd2
   } lane_type;

   typedef struct packed {
      logic      act;
      lane_type  src1;
      logic      neg1;
      lane_type  src2;
      logic      neg2;
      phase_type first;
      phase_type mid;
      phase_type last;
   } sector_info_type;

   // sideband through the x y z divider
   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [2:0]       neg;
   } front_sb_type;

   // sideband through the overmodulation divider
   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic             act;
      logic             scale;
      logic [XM_W-1:0]  t1;
      logic [XM_W-1:0]  t2;
   } back_sb_type;

   // sqrt3 rounded to frac fraction bits
   function automatic logic [21:0] sqrt3_q(input int frac);
      logic [21:0] t;
      t = (SQRT3_Q21 >> (20 - frac)) + 22'd1;
      return t >> 1;
   endfunction

   // active vector sources and phase order for each sector
   function automatic sector_info_type sector_info(input logic [SEC_W-1:0] sec);
      sector_info_type r;
      r = '{act: 1'b1, src1: LN_X, neg1: 1'b0, src2: LN_X, neg2: 1'b0,
            first: PH_A, mid: PH_B, last: PH_C};
      unique case (sec)
         3'd1: r = '{1'b1, LN_Y, 1'b1, LN_Z, 1'b1, PH_B, PH_A, PH_C};
         3'd2: r = '{1'b1, LN_Z, 1'b1, LN_X, 1'b1, PH_A, PH_C, PH_B};
         3'd3: r = '{1'b1, LN_Y, 1'b0, LN_X, 1'b0, PH_A, PH_B, PH_C};
         3'd4: r = '{1'b1, LN_X, 1'b1, LN_Y, 1'b1, PH_C, PH_B, PH_A};
         3'd5: r = '{1'b1, LN_X, 1'b0, LN_Z, 1'b0, PH_B, PH_C, PH_A};
         3'd6: r = '{1'b1, LN_Z, 1'b0, LN_Y, 1'b0, PH_C, PH_A, PH_B};
         default: r.act = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/svpd_div.sv
// svpd_div: pipelined restoring divider, several lanes sharing one divisor,
// a fixed number of quotient bits per stage. uses no package.
`timescale 1ns / 1ps
`default_nettype none

module svpd_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8,
   parameter int LANES = 1,
   parameter int STEP  = 1,
   parameter int SB_W  = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              vld_in,
   input  wire logic [LANES-1:0][DEN_W-1:0]       rem_start,
   input  wire logic [LANES-1:0][NUM_W-1:0]       num_start,
   input  wire logic [DEN_W-1:0]                  den_in,
   input  wire logic [SB_W-1:0]                   sb_in,
   output logic                                   vld_out,
   output logic [LANES-1:0][NUM_W-1:0]            quo_out,
   output logic [SB_W-1:0]                        sb_out
);

   localparam int NSTG = NUM_W / STEP;

   logic [NSTG-1:0]                  vld_ff;
   logic [NSTG-1:0]                  vld_in_s;
   logic [LANES-1:0][DEN_W-1:0]      src_rem    [NSTG];
   logic [LANES-1:0][NUM_W-1:0]      src_nq     [NSTG];
   logic [DEN_W-1:0]                 src_den    [NSTG];
   logic [SB_W-1:0]                  src_sb     [NSTG];
   logic [LANES-1:0][DEN_W-1:0]      stg_rem_in [NSTG];
   logic [LANES-1:0][NUM_W-1:0]      stg_nq_in  [NSTG];
   logic [LANES-1:0][DEN_W-1:0]      stg_rem_ff [NSTG];
   logic [LANES-1:0][NUM_W-1:0]      stg_nq_ff  [NSTG];
   logic [DEN_W-1:0]                 stg_den_ff [NSTG];
   logic [SB_W-1:0]                  stg_sb_ff  [NSTG];

   // STEP shift and subtract steps on one lane
   function automatic logic [DEN_W+NUM_W-1:0] div_step(
      input logic [DEN_W-1:0] rem,
      input logic [NUM_W-1:0] nq,
      input logic [DEN_W-1:0] den
   );
      logic [DEN_W:0]   r;
      logic [DEN_W-1:0] rr;
      logic [NUM_W-1:0] n;
      rr = rem;
      n  = nq;
      for (int i = 0; i < STEP; i++) begin
         r = {rr, n[NUM_W-1]};
         n = {n[NUM_W-2:0], 1'b0};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            n[0] = 1'b1;
         end
         rr = r[DEN_W-1:0];
      end
      return {rr, n};
   endfunction

   // stage sources: first stage from the ports, others from the stage before
   always_comb begin
      src_rem[0]  = rem_start;
      src_nq[0]   = num_start;
      src_den[0]  = den_in;
      src_sb[0]   = sb_in;
      vld_in_s[0] = vld_in;
      for (int g = 1; g < NSTG; g++) begin
         src_rem[g]  = stg_rem_ff[g-1];
         src_nq[g]   = stg_nq_ff[g-1];
         src_den[g]  = stg_den_ff[g-1];
         src_sb[g]   = stg_sb_ff[g-1];
         vld_in_s[g] = vld_ff[g-1];
      end
   end

   // one group of quotient bits per stage and lane
   always_comb begin
      for (int g = 0; g < NSTG; g++) begin
         for (int l = 0; l < LANES; l++) begin
            {stg_rem_in[g][l], stg_nq_in[g][l]} = div_step(src_rem[g][l], src_nq[g][l],
                                                           src_den[g]);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in_s;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < NSTG; g++) begin
            stg_rem_ff[g] <= stg_rem_in[g];
            stg_nq_ff[g]  <= stg_nq_in[g];
            stg_den_ff[g] <= src_den[g];
            stg_sb_ff[g]  <= src_sb[g];
         end
      end
   end

   assign vld_out = vld_ff[NSTG-1];
   assign quo_out = stg_nq_ff[NSTG-1];
   assign sb_out  = stg_sb_ff[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/svpd_front.sv
// svpd_front: projections, sector code and the scaled numerators of x y z.
// five register stages; depends on svpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpd_front #(
   parameter int FRAC_BITS = svpd_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              en,
   input  wire logic                                              vld_in,
   input  wire logic signed [svpd_pkg::IN_W-1:0]                  v_alpha,
   input  wire logic signed [svpd_pkg::IN_W-1:0]                  v_beta,
   input  wire logic [svpd_pkg::TS_W-1:0]                         ts,
   output logic                                                   vld_out,
   output logic [svpd_pkg::LANES_XYZ-1:0][svpd_pkg::XM_W-1:0]     num_out,
   output svpd_pkg::front_sb_type                                 sb_out
);

   import svpd_pkg::*;

   localparam int QU_W = FRAC_BITS + 1;
   localparam int S_W  = QU_W + 1 + IN_W;
   localparam int D_W  = S_W + 1;
   localparam int M1_W = QU_W + UM_W;
   localparam int M2_W = M1_W + TS_W;
   localparam logic [QU_W-1:0] SQ = QU_W'(sqrt3_q(FRAC_BITS));

   logic [4:0]                      vld_ff;
   logic signed [S_W-1:0]           s_ff, s_in;
   logic signed [IN_W-1:0]          beta_ff;
   logic signed [D_W-1:0]           db, dc;
   logic signed [U_W-1:0]           u_ff [3];
   logic signed [U_W-1:0]           u_in [3];
   logic [SEC_W-1:0]                sec2_ff, sec2_in, sec3_ff, sec4_ff, sec5_ff;
   logic [2:0]                      neg3_ff, neg3_in, neg4_ff, neg5_ff;
   logic [UM_W-1:0]                 mag_ff [3];
   logic [UM_W-1:0]                 mag_in [3];
   logic [M1_W-1:0]                 m1_ff [3];
   logic [M2_W-1:0]                 m2_ff [3];

   // sqrt3 times alpha
   assign s_in = $signed({1'b0, SQ}) * v_alpha;

   // projections rounded at input scale, and their signs
   always_comb begin
      db = D_W'(s_ff) - (D_W'(beta_ff) <<< FRAC_BITS) + (D_W'(1) <<< FRAC_BITS);
      dc = -D_W'(s_ff) - (D_W'(beta_ff) <<< FRAC_BITS) + (D_W'(1) <<< FRAC_BITS);
      u_in[0] = U_W'(beta_ff);
      u_in[1] = db[D_W-1:FRAC_BITS+1];
      u_in[2] = dc[D_W-1:FRAC_BITS+1];
      sec2_in = {u_in[2] > 0, u_in[1] > 0, u_in[0] > 0};
   end

   // sign and magnitude
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg3_in[k] = u_ff[k][U_W-1];
         mag_in[k]  = neg3_in[k] ? UM_W'(-u_ff[k]) : UM_W'(u_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], vld_in};
      end
   end

   // payload stages: product, projections, magnitude, times sqrt3, times ts
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         beta_ff <= v_beta;
         sec2_ff <= sec2_in;
         sec3_ff <= sec2_ff;
         neg3_ff <= neg3_in;
         sec4_ff <= sec3_ff;
         neg4_ff <= neg3_ff;
         sec5_ff <= sec4_ff;
         neg5_ff <= neg4_ff;
         for (int k = 0; k < 3; k++) begin
            u_ff[k]   <= u_in[k];
            mag_ff[k] <= mag_in[k];
            m1_ff[k]  <= SQ * mag_ff[k];
            m2_ff[k]  <= m1_ff[k] * ts;
         end
      end
   end

   // drop the fixed point scale: bus voltage is divided out downstream
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_out[k] = m2_ff[k][M2_W-1 -: XM_W];
      end
   end

   assign vld_out       = vld_ff[4];
   assign sb_out.sector = sec5_ff;
   assign sb_out.neg    = neg5_ff;

endmodule

`default_nettype wire

>>> rtl/svpd_time.sv
// svpd_time: signed x y z, active vector times for the sector, their sum and
// the products for the overmodulation scaling. depends on svpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpd_time (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              en,
   input  wire logic                                              vld_in,
   input  wire logic [svpd_pkg::LANES_XYZ-1:0][svpd_pkg::XM_W-1:0] mag_in,
   input  wire svpd_pkg::front_sb_type                            sb_in,
   input  wire logic [svpd_pkg::TS_W-1:0]                         ts,
   output logic                                                   vld_out,
   output logic [svpd_pkg::LANES_T-1:0][svpd_pkg::SUM_W-1:0]      rem_start,
   output logic [svpd_pkg::LANES_T-1:0][svpd_pkg::TS_W-1:0]       num_start,
   output logic [svpd_pkg::SUM_W-1:0]                             den_out,
   output svpd_pkg::back_sb_type                                  sb_out
);

   import svpd_pkg::*;

   localparam int XS_W = XM_W + 1;
   localparam int PR_W = XM_W + TS_W;

   logic [2:0]               vld_ff;
   logic signed [XS_W-1:0]   xs_ff [3];
   logic [SEC_W-1:0]         sec1_ff, sec2_ff, sec3_ff;
   sector_info_type          info;
   logic [XM_W-1:0]          t1_ff, t1_in, t2_ff, t2_in, t1b_ff, t2b_ff;
   logic                     act2_ff, act3_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [PR_W-1:0]          p1_ff, p2_ff;

   assign info = sector_info(sec1_ff);

   // pick the two active vector times
   always_comb begin
      t1_in = info.neg1 ? XM_W'(-xs_ff[info.src1]) : XM_W'(xs_ff[info.src1]);
      t2_in = info.neg2 ? XM_W'(-xs_ff[info.src2]) : XM_W'(xs_ff[info.src2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], vld_in};
      end
   end

   // payload stages: sign restore, selection, sum and products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            xs_ff[k] <= sb_in.neg[k] ? -$signed({1'b0, mag_in[k]}) : $signed({1'b0, mag_in[k]});
         end
         sec1_ff <= sb_in.sector;
         sec2_ff <= sec1_ff;
         act2_ff <= info.act;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         sec3_ff <= sec2_ff;
         act3_ff <= act2_ff;
         t1b_ff  <= t1_ff;
         t2b_ff  <= t2_ff;
         sum_ff  <= SUM_W'(t1_ff) + SUM_W'(t2_ff);
         p1_ff   <= t1_ff * ts;
         p2_ff   <= t2_ff * ts;
      end
   end

   // t*ts/sum: high part of the product is below the sum when scaling applies
   assign rem_start[0] = SUM_W'(p1_ff[PR_W-1:TS_W]);
   assign rem_start[1] = SUM_W'(p2_ff[PR_W-1:TS_W]);
   assign num_start[0] = p1_ff[TS_W-1:0];
   assign num_start[1] = p2_ff[TS_W-1:0];
   assign den_out      = sum_ff;

   assign vld_out       = vld_ff[2];
   assign sb_out.sector = sec3_ff;
   assign sb_out.act    = act3_ff;
   assign sb_out.scale  = SUM_W'(ts) < sum_ff;
   assign sb_out.t1     = t1b_ff;
   assign sb_out.t2     = t2b_ff;

endmodule

`default_nettype wire

>>> rtl/svpd_duty.sv
// svpd_duty: final times, centre aligned on-times, inversion and clamp.
// three stages, the last one is the result register; depends on svpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpd_duty (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              en,
   input  wire logic                                              vld_in,
   input  wire logic [svpd_pkg::LANES_T-1:0][svpd_pkg::TS_W-1:0]  quo_in,
   input  wire svpd_pkg::back_sb_type                             sb_in,
   input  wire logic [svpd_pkg::TS_W-1:0]                         ts,
   input  wire logic [svpd_pkg::TS_W-1:0]                         period,
   input  wire logic [svpd_pkg::TS_W-1:0]                         limit,
   output logic                                                   vld_out,
   output logic [svpd_pkg::CMP_W-1:0]                             compare_a,
   output logic [svpd_pkg::CMP_W-1:0]                             compare_b,
   output logic [svpd_pkg::CMP_W-1:0]                             compare_c,
   output logic [svpd_pkg::SEC_W-1:0]                             sector_code
);

   import svpd_pkg::*;

   localparam int DF_W = XM_W + 2;

   logic [2:0]               vld_ff;
   logic [XM_W-1:0]          t1f, t2f;
   logic [DF_W-1:0]          diff;
   logic [XM_W-1:0]          t1_ff, t2_ff;
   logic [CMP_W-1:0]         first_ff;
   logic                     act1_ff, act1_in, act2_ff;
   logic [SEC_W-1:0]         sec1_ff, sec2_ff;
   sector_info_type          info;
   logic [CMP_W-1:0]         on_mid, on_last;
   logic [CMP_W-1:0]         on_ff [3];
   logic [CMP_W-1:0]         on_in [3];
   logic [CMP_W-1:0]         cmp_ff [3];
   logic [CMP_W-1:0]         cmp_in [3];
   logic [SEC_W-1:0]         sec_out_ff;

   // scaled or unscaled times, zero time check, first on-time
   always_comb begin
      t1f     = sb_in.scale ? XM_W'(quo_in[0]) : sb_in.t1;
      t2f     = sb_in.scale ? XM_W'(quo_in[1]) : sb_in.t2;
      act1_in = sb_in.act && !(t1f == '0 && t2f == '0);
      diff    = DF_W'(ts) - DF_W'(t1f) - DF_W'(t2f);
   end

   // later on-times, placed on the phases in sector order
   always_comb begin
      info    = sector_info(sec1_ff);
      on_mid  = first_ff + t1_ff[CMP_W:1];
      on_last = on_mid + t2_ff[CMP_W:1];
      on_in[0] = first_ff;
      on_in[1] = first_ff;
      on_in[2] = first_ff;
      on_in[info.mid]  = on_mid;
      on_in[info.last] = on_last;
   end

   // invert against the period and clamp at the pulse limit
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cmp_in[k] = act2_ff ? period - on_ff[k] : period;
         if (cmp_in[k] >= limit) begin
            cmp_in[k] = limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff      <= t1f;
         t2_ff      <= t2f;
         first_ff   <= diff[CMP_W+1:2];
         act1_ff    <= act1_in;
         sec1_ff    <= sb_in.sector;
         act2_ff    <= act1_ff;
         sec2_ff    <= sec1_ff;
         on_ff      <= on_in;
         cmp_ff     <= cmp_in;
         sec_out_ff <= sec2_ff;
      end
   end

   assign vld_out     = vld_ff[2];
   assign compare_a   = cmp_ff[0];
   assign compare_b   = cmp_ff[1];
   assign compare_c   = cmp_ff[2];
   assign sector_code = sec_out_ff;

endmodule

`default_nettype wire

>>> rtl/space_vector_pwm_duty.sv
// space_vector_pwm_duty: top level, register port, stream ports and the pipeline.
// depends on svpd_pkg, svpd_front, svpd_div, svpd_time and svpd_duty.
`timescale 1ns / 1ps
`default_nettype none

// Takes one alpha/beta voltage pair per item and returns the three phase
// compare values of a centre aligned seven segment space vector pwm plus the
// sector code. One item is taken every clock cycle while no result is held;
// each result passes through projection and multiplication, the bus voltage
// divider (four quotient bits per stage), time selection, the overmodulation
// divider (one quotient bit per stage) and on-time, inversion and clamp. The
// whole pipeline holds while a result waits on rsp_tready, so req_tready drops
// only then. Registers must be written only while no item is in flight; the
// block itself does not enforce this.
module space_vector_pwm_duty #(
   parameter int FRAC_BITS = svpd_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // v_alpha [23:0], v_beta [47:24]
   input  wire logic [47:0]                         req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // compare_a [15:0], compare_b [31:16], compare_c [47:32], sector_code [50:48]
   output logic [55:0]                              rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [svpd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [svpd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [svpd_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   import svpd_pkg::*;

   logic [UDC_W-1:0]                   udc_ff;
   logic [TS_W-1:0]                    ts_ff, period_ff, limit_ff;
   logic [UDC_W-1:0]                   udc_den;
   logic                               csr_wr;
   reg_type                            csr_reg;
   logic                               en;

   logic                               f_vld;
   logic [LANES_XYZ-1:0][XM_W-1:0]     f_num;
   front_sb_type                       f_sb;
   logic                               d1_vld;
   logic [LANES_XYZ-1:0][XM_W-1:0]     d1_quo;
   front_sb_type                       d1_sb;
   logic                               t_vld;
   logic [LANES_T-1:0][SUM_W-1:0]      t_rem;
   logic [LANES_T-1:0][TS_W-1:0]       t_num;
   logic [SUM_W-1:0]                   t_den;
   back_sb_type                        t_sb;
   logic                               d2_vld;
   logic [LANES_T-1:0][TS_W-1:0]       d2_quo;
   back_sb_type                        d2_sb;
   logic [CMP_W-1:0]                   cmp_a, cmp_b, cmp_c;
   logic [SEC_W-1:0]                   sector;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         udc_ff    <= UDC_RST;
         ts_ff     <= TS_RST;
         period_ff <= PERIOD_RST;
         limit_ff  <= LIMIT_RST;
      end else if (csr_wr) begin
         unique case (csr_reg)
            REG_UDC:    udc_ff    <= csr_pwdata[UDC_W-1:0];
            REG_TS:     ts_ff     <= csr_pwdata[TS_W-1:0];
            REG_PERIOD: period_ff <= csr_pwdata[TS_W-1:0];
            REG_LIMIT:  limit_ff  <= csr_pwdata[TS_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_reg)
         REG_UDC:    csr_prdata = CSR_DATA_W'(udc_ff);
         REG_TS:     csr_prdata = CSR_DATA_W'(ts_ff);
         REG_PERIOD: csr_prdata = CSR_DATA_W'(period_ff);
         REG_LIMIT:  csr_prdata = CSR_DATA_W'(limit_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // zero bus voltage divides as one
   assign udc_den = (udc_ff == '0) ? UDC_W'(1) : udc_ff;

   // the whole pipeline moves unless a result is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   svpd_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .vld_in  (req_tvalid),
      .v_alpha (req_tdata[23:0]),
      .v_beta  (req_tdata[47:24]),
      .ts      (ts_ff),
      .vld_out (f_vld),
      .num_out (f_num),
      .sb_out  (f_sb)
   );

   // x y z divided by the bus voltage
   svpd_div #(
      .NUM_W (XM_W),
      .DEN_W (UDC_W),
      .LANES (LANES_XYZ),
      .STEP  (STEP_XYZ),
      .SB_W  ($bits(front_sb_type))
   ) u_div_xyz (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_in    (f_vld),
      .rem_start ('0),
      .num_start (f_num),
      .den_in    (udc_den),
      .sb_in     (f_sb),
      .vld_out   (d1_vld),
      .quo_out   (d1_quo),
      .sb_out    (d1_sb)
   );

   svpd_time u_time (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_in    (d1_vld),
      .mag_in    (d1_quo),
      .sb_in     (d1_sb),
      .ts        (ts_ff),
      .vld_out   (t_vld),
      .rem_start (t_rem),
      .num_start (t_num),
      .den_out   (t_den),
      .sb_out    (t_sb)
   );

   // overmodulation scaling t*ts/sum
   svpd_div #(
      .NUM_W (TS_W),
      .DEN_W (SUM_W),
      .LANES (LANES_T),
      .STEP  (STEP_T),
      .SB_W  ($bits(back_sb_type))
   ) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .vld_in    (t_vld),
      .rem_start (t_rem),
      .num_start (t_num),
      .den_in    (t_den),
      .sb_in     (t_sb),
      .vld_out   (d2_vld),
      .quo_out   (d2_quo),
      .sb_out    (d2_sb)
   );

   svpd_duty u_duty (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .vld_in      (d2_vld),
      .quo_in      (d2_quo),
      .sb_in       (d2_sb),
      .ts          (ts_ff),
      .period      (period_ff),
      .limit       (limit_ff),
      .vld_out     (rsp_tvalid),
      .compare_a   (cmp_a),
      .compare_b   (cmp_b),
      .compare_c   (cmp_c),
      .sector_code (sector)
   );

   assign rsp_tdata = {5'b0, sector, cmp_c, cmp_b, cmp_a};

   // every compare stays at or below the pulse limit
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cmp_a <= limit_ff && cmp_b <= limit_ff && cmp_c <= limit_ff))
      else $error("compare above pulse limit");

   // zero vector sectors drive all phases alike
   a_idle_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (sector == 3'd0 || sector == 3'd7) |-> (cmp_a == cmp_b && cmp_b == cmp_c))
      else $error("idle sector with unequal compares");

   // a held result keeps the pipeline frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(d2_vld) && $stable(t_vld) && $stable(f_vld))
      else $error("pipeline moved while result held");

endmodule

`default_nettype wire

>>> test/space_vector_pwm_duty_tb.sv
// space_vector_pwm_duty_tb: self-checking bench for the space vector pwm duty block.
// depends on svpd_pkg and space_vector_pwm_duty; predicts compares and sector per item.
`timescale 1ns / 1ps

module space_vector_pwm_duty_tb;
   import svpd_pkg::*;

   localparam longint SQRT3_Q = ((longint'(SQRT3_Q21) >> (20 - FRAC_BITS_DEF)) + 1) >> 1;
   localparam longint VMAX    = 8388607;
   localparam longint VMIN    = -8388608;

   typedef struct {
      logic [15:0] cmp_a;
      logic [15:0] cmp_b;
      logic [15:0] cmp_c;
      logic [2:0]  sector;
   } duty_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   logic [47:0] req_tdata;   // v_alpha [23:0], v_beta [47:24]
   wire         rsp_tvalid;
   logic        rsp_tready;
   wire  [55:0] rsp_tdata;   // compare_a, compare_b, compare_c, sector_code [50:48]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   wire  [CSR_DATA_W-1:0] csr_prdata;
   wire         csr_pready;

   // register shadow used by the predictor
   logic [7:0]  udc_q;
   logic [15:0] ts_q;
   logic [15:0] period_q;
   logic [15:0] limit_q;

   logic [47:0] pending_pairs[$];
   duty_type    expected_duty[$];
   int          gap_left;
   int          rsp_gap;
   bit          no_idle;
   int          fails;

   space_vector_pwm_duty DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic longint trunc_div(longint num, longint den);
      return num / den;
   endfunction

   // compare values and sector code of one voltage pair
   function automatic duty_type predict_duty(logic [23:0] va, logic [23:0] vb);
      longint   alpha, beta, s, bf, ua, ub, uc, den, ts, x, y, z, t1, t2, sum;
      longint   on_t[3];
      longint   c;
      int       first, mid, last;
      bit       idle;
      logic [2:0] sec;
      duty_type r;
      alpha = longint'($signed(va));
      beta  = longint'($signed(vb));
      s  = SQRT3_Q * alpha;
      bf = beta <<< FRAC_BITS_DEF;
      ua = beta;
      ub = (s - bf + (longint'(1) <<< FRAC_BITS_DEF)) >>> (FRAC_BITS_DEF + 1);
      uc = (-s - bf + (longint'(1) <<< FRAC_BITS_DEF)) >>> (FRAC_BITS_DEF + 1);
      sec = {uc > 0, ub > 0, ua > 0};
      den = longint'(udc_q == 0 ? 8'd1 : udc_q) <<< (15 + FRAC_BITS_DEF);
      ts  = longint'(ts_q);
      x = trunc_div(SQRT3_Q * ua * ts, den);
      y = trunc_div(SQRT3_Q * ub * ts, den);
      z = trunc_div(SQRT3_Q * uc * ts, den);
      t1 = 0; t2 = 0; first = 0; mid = 1; last = 2; idle = 1'b0;
      on_t = '{0, 0, 0};
      case (sec)
         3'd1: begin t1 = -y; t2 = -z; first = PH_B; mid = PH_A; last = PH_C; end
         3'd2: begin t1 = -z; t2 = -x; first = PH_A; mid = PH_C; last = PH_B; end
         3'd3: begin t1 = y;  t2 = x;  first = PH_A; mid = PH_B; last = PH_C; end
         3'd4: begin t1 = -x; t2 = -y; first = PH_C; mid = PH_B; last = PH_A; end
         3'd5: begin t1 = x;  t2 = z;  first = PH_B; mid = PH_C; last = PH_A; end
         3'd6: begin t1 = z;  t2 = y;  first = PH_C; mid = PH_A; last = PH_B; end
         default: idle = 1'b1;
      endcase
      if (!idle) begin
         // overmodulation scaling uses the unscaled sum for both times
         sum = t1 + t2;
         if (ts < sum) begin
            t1 = t1 * ts / sum;
            t2 = t2 * ts / sum;
         end
         if (t1 == 0 && t2 == 0) idle = 1'b1;
         on_t[first] = (ts - t1 - t2) / 4;
         on_t[mid]   = on_t[first] + t1 / 2;
         on_t[last]  = on_t[mid] + t2 / 2;
      end
      for (int k = 0; k < 3; k++) begin
         if (idle) c = period_q;
         else c = (longint'(period_q) - (on_t[k] & 16'hFFFF)) & 16'hFFFF;
         if (c >= limit_q) c = limit_q;
         on_t[k] = c;
      end
      r.cmp_a  = on_t[0][15:0];
      r.cmp_b  = on_t[1][15:0];
      r.cmp_c  = on_t[2][15:0];
      r.sector = sec;
      return r;
   endfunction

   // driver: feeds queued pairs, records expectations on acceptance
   always @(posedge clock) begin
      logic        nv;
      logic [47:0] nd;
      nv = req_tvalid;
      nd = req_tdata;
      if (reset) begin
         nv = 1'b0;
         gap_left = 0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid && req_tready)
            expected_duty.push_back(predict_duty(req_tdata[23:0], req_tdata[47:24]));
         if (gap_left > 0) begin
            gap_left--;
            nv = 1'b0;
         end else if (pending_pairs.size() > 0) begin
            nd = pending_pairs.pop_front();
            nv = 1'b1;
            gap_left = pick_gap();
         end else begin
            nv = 1'b0;
         end
      end
      req_tvalid <= nv;
      req_tdata  <= nd;
   end

   // monitor: random backpressure in runs and field checks
   always @(posedge clock) begin
      duty_type e;
      if (reset) begin
         rsp_gap = 0;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_gap = pick_gap();
         rsp_tready <= (rsp_gap == 0);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_duty.size() == 0) begin
            $display("%0t: unexpected item, actual %h", $time, rsp_tdata);
            fails++;
         end else begin
            e = expected_duty.pop_front();
            if (rsp_tdata[15:0] !== e.cmp_a) begin
               $display("%0t: compare_a expected %0d actual %0d", $time, e.cmp_a,
                        rsp_tdata[15:0]);
               fails++;
            end
            if (rsp_tdata[31:16] !== e.cmp_b) begin
               $display("%0t: compare_b expected %0d actual %0d", $time, e.cmp_b,
                        rsp_tdata[31:16]);
               fails++;
            end
            if (rsp_tdata[47:32] !== e.cmp_c) begin
               $display("%0t: compare_c expected %0d actual %0d", $time, e.cmp_c,
                        rsp_tdata[47:32]);
               fails++;
            end
            if (rsp_tdata[50:48] !== e.sector) begin
               $display("%0t: sector expected %0d actual %0d", $time, e.sector,
                        rsp_tdata[50:48]);
               fails++;
            end
         end
      end
   end

   task automatic csr_write(reg_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_UDC:    udc_q    = value[7:0];
         REG_TS:     ts_q     = value[15:0];
         REG_PERIOD: period_q = value[15:0];
         default:    limit_q  = value[15:0];
      endcase
   endtask

   task automatic set_regs(logic [7:0] udc, logic [15:0] ts, logic [15:0] per,
                           logic [15:0] lim);
      csr_write(REG_UDC, 32'(udc));
      csr_write(REG_TS, 32'(ts));
      csr_write(REG_PERIOD, 32'(per));
      csr_write(REG_LIMIT, 32'(lim));
   endtask

   // hold off until every item has come back and the pipeline is empty
   task automatic drain();
      do @(posedge clock);
      while (pending_pairs.size() > 0 || req_tvalid || expected_duty.size() > 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_pair(longint va, longint vb);
      pending_pairs.push_back({vb[23:0], va[23:0]});
   endtask

   // random pairs: full range, mid magnitude near the hexagon, and tiny
   task automatic push_random(int n);
      int   m;
      longint va, vb;
      for (int i = 0; i < n; i++) begin
         m = $urandom_range(9);
         if (m < 3) begin
            va = longint'($signed(24'($urandom)));
            vb = longint'($signed(24'($urandom)));
         end else if (m < 8) begin
            va = longint'($urandom_range(800000)) - 400000;
            vb = longint'($urandom_range(800000)) - 400000;
         end else begin
            va = longint'($urandom_range(64)) - 32;
            vb = longint'($urandom_range(64)) - 32;
         end
         push_pair(va, vb);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      udc_q    = UDC_RST;
      ts_q     = TS_RST;
      period_q = PERIOD_RST;
      limit_q  = LIMIT_RST;
      no_idle  = 1'b0;
      fails    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero vector, tiny times, overmodulation
      push_pair(0, 0);
      push_pair(VMAX, 0);
      push_pair(VMIN, 0);
      push_pair(0, VMAX);
      push_pair(0, VMIN);
      push_pair(VMAX, VMAX);
      push_pair(VMIN, VMIN);
      push_pair(VMAX, VMIN);
      push_pair(VMIN, VMAX);
      push_pair(1, 0);
      push_pair(-1, 0);
      push_pair(0, 1);
      push_pair(0, -1);
      push_pair(1, 1);
      push_pair(-1, -1);
      push_pair(300000, 100000);
      push_pair(-300000, 100000);
      push_pair(0, -300000);
      push_pair(-200000, -150000);
      push_pair(200000, -150000);
      drain();

      // settings: default, upper extremes, lower extremes, zero bus, random
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_regs(UDC_RST, TS_RST, PERIOD_RST, LIMIT_RST);
            1: set_regs(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_regs(8'd255, 16'd1, 16'd1, 16'd0);
            3: set_regs(8'd0, 16'd3600, 16'd4000, 16'hFFFF);
            default: set_regs(8'($urandom_range(255, 1)), 16'($urandom_range(65535, 1)),
                              16'($urandom_range(65535, 1)), 16'($urandom_range(65535)));
         endcase
         no_idle = (ph % 3 == 1);
         push_random(120);
         drain();
      end

      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/svpd_pkg.sv
rtl/svpd_div.sv
rtl/svpd_front.sv
rtl/svpd_time.sv
rtl/svpd_duty.sv
rtl/space_vector_pwm_duty.sv
test/space_vector_pwm_duty_tb.sv
